// File: rtl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants of the request slot allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = $clog2(SLOTS);      // slot index inside the block
	localparam int CNT_W  = $clog2(SLOTS + 1);  // free stack fill count
	localparam int IDX_W  = 6;                  // slot index field on the ports
	localparam int KIND_W = 8;
	localparam int HDL_W  = 64;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_LOOKUP  = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;
	localparam logic [1:0] STS_FREE  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [HDL_W-1:0]  future;
		logic [HDL_W-1:0]  buffer;
	} slot_rec_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the item, launch the stack and slot reads
		logic execute;  // decide, update state, register the result
	} rsa_cmd_t;

endpackage

// File: rtl/rsa_ram.sv
// ----------------------------------------------------------------------------
// rsa_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/rsa_ctrl.sv
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer: capture an item, execute it in the following cycle.
// ----------------------------------------------------------------------------
module rsa_ctrl
	import rsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output rsa_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign cmd.capture = start && (state_q == S_IDLE);
	assign cmd.execute = (state_q == S_EXEC);

endmodule

// File: rtl/rsa_dp.sv
// ----------------------------------------------------------------------------
// rsa_dp
// Datapath: free index stack, occupancy bits, slot store and result register.
// ----------------------------------------------------------------------------
module rsa_dp
	import rsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  rsa_cmd_t          cmd,
	input  logic [1:0]        opcode,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [KIND_W-1:0] request_kind,
	input  logic [HDL_W-1:0]  future_handle,
	input  logic [HDL_W-1:0]  buffer_handle,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  granted_index,
	output logic [KIND_W-1:0] stored_kind,
	output logic [HDL_W-1:0]  stored_future,
	output logic [HDL_W-1:0]  stored_buffer
);

	// captured item
	logic [1:0]       op_q;
	logic [IDX_W-1:0] idx_q;
	slot_rec_t        rec_q;

	// free stack: fill count, plus a written bit per entry; an unwritten
	// entry reads as its own position
	logic [CNT_W-1:0]  fill_q;
	logic [SLOTS-1:0]  stk_vld_q;
	logic              stk_vld_rd_q;
	logic [SLOT_W-1:0] top_pos;
	logic [SLOT_W-1:0] stk_rdata;
	logic [SLOT_W-1:0] popped;

	logic [SLOTS-1:0] occ_q;

	slot_rec_t slot_rdata;

	// execute-cycle decisions
	logic              stk_we;
	logic [SLOT_W-1:0] stk_waddr;
	logic              slot_we;
	logic              occ_set;
	logic              occ_clr;
	logic [SLOT_W-1:0] occ_pos;
	logic              fill_dec;
	logic              fill_inc;
	logic              in_range;
	logic [1:0]        sts_nxt;
	logic [IDX_W-1:0]  gidx_nxt;
	slot_rec_t         out_nxt;

	logic              strobe_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  granted_q;
	slot_rec_t         out_q;

	assign top_pos = SLOT_W'(fill_q - 1'b1);
	assign popped  = stk_vld_rd_q ? stk_rdata : top_pos;
	assign occ_pos = SLOT_W'(idx_q);

	rsa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(occ_pos),
		.re   (cmd.capture),
		.raddr(top_pos),
		.rdata(stk_rdata)
	);

	rsa_ram #(
		.WIDTH($bits(slot_rec_t)),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(popped),
		.wdata(rec_q),
		.re   (cmd.capture),
		.raddr(SLOT_W'(slot_index)),
		.rdata(slot_rdata)
	);

	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = SLOT_W'(fill_q);
		slot_we   = 1'b0;
		occ_set   = 1'b0;
		occ_clr   = 1'b0;
		fill_dec  = 1'b0;
		fill_inc  = 1'b0;
		in_range  = (32'(idx_q) < SLOTS);
		sts_nxt   = STS_OK;
		gidx_nxt  = idx_q;
		out_nxt   = '0;
		case (op_q)
			OP_ALLOC: begin
				if (fill_q == '0) begin
					sts_nxt  = STS_FULL;
					gidx_nxt = '0;
				end else begin
					gidx_nxt = IDX_W'(popped);
					slot_we  = cmd.execute;
					fill_dec = 1'b1;
				end
			end
			OP_LOOKUP, OP_RELEASE: begin
				if (!in_range) begin
					sts_nxt = STS_RANGE;
				end else if (!occ_q[occ_pos]) begin
					sts_nxt = STS_FREE;
				end else if (op_q == OP_LOOKUP) begin
					out_nxt = slot_rdata;
				end else begin
					occ_clr = 1'b1;
					if (fill_q < CNT_W'(SLOTS)) begin
						stk_we   = cmd.execute;
						fill_inc = 1'b1;
					end
				end
			end
			default: sts_nxt = STS_RANGE;
		endcase
		// allocate marks the popped slot
		occ_set = fill_dec;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= opcode;
			idx_q        <= slot_index;
			rec_q.kind   <= request_kind;
			rec_q.future <= future_handle;
			rec_q.buffer <= buffer_handle;
			stk_vld_rd_q <= stk_vld_q[top_pos];
		end
		if (cmd.execute) begin
			status_q  <= sts_nxt;
			granted_q <= gidx_nxt;
			out_q     <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= CNT_W'(SLOTS);
			stk_vld_q <= '0;
			occ_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= cmd.execute;
			if (cmd.execute) begin
				if (fill_dec) begin
					fill_q <= fill_q - 1'b1;
				end else if (fill_inc) begin
					fill_q <= fill_q + 1'b1;
				end
				if (stk_we) begin
					stk_vld_q[stk_waddr] <= 1'b1;
				end
				if (occ_set) begin
					occ_q[popped] <= 1'b1;
				end else if (occ_clr) begin
					occ_q[occ_pos] <= 1'b0;
				end
			end
		end
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign stored_kind   = out_q.kind;
	assign stored_future = out_q.future;
	assign stored_buffer = out_q.buffer;

endmodule

// File: rtl/request_slot_allocator_top.sv
// The allocator takes an item when start is high while busy is low and drives
// its result for exactly one cycle with strobe high; the result cannot be
// held off and must be taken then. Busy is low again in the strobe cycle, so
// a new item can be started then, but not while the last one is executing.
// Capture and execute are separate steps because of the registered read of
// the free stack and slot memories: the capture cycle launches both reads,
// the next cycle pops or pushes the stack, updates the slot and registers the
// result. The stack starts full, so the first allocation gets the highest index.
// ----------------------------------------------------------------------------
// request_slot_allocator_top
// Outstanding request tag allocator on a free index stack.
// ----------------------------------------------------------------------------
module request_slot_allocator_top
	import rsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [KIND_W-1:0] request_kind,
	input  logic [HDL_W-1:0]  future_handle,
	input  logic [HDL_W-1:0]  buffer_handle,
	output logic              strobe,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  granted_index,
	output logic [KIND_W-1:0] stored_kind,
	output logic [HDL_W-1:0]  stored_future,
	output logic [HDL_W-1:0]  stored_buffer
);

	rsa_cmd_t cmd;

	rsa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	rsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.slot_index   (slot_index),
		.request_kind (request_kind),
		.future_handle(future_handle),
		.buffer_handle(buffer_handle),
		.strobe       (strobe),
		.status       (status),
		.granted_index(granted_index),
		.stored_kind  (stored_kind),
		.stored_future(stored_future),
		.stored_buffer(stored_buffer)
	);

endmodule

// File: tb/sv/request_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_slot_allocator_top_tb
// Self-checking bench for the request slot allocator. A queue of items, first
// directed cases and then fill, drain and mixed bursts, feeds a clocked
// driver. Accepted items run through a local free stack and slot store that
// predict each result. A monitor checks every strobed result field by field.
// ----------------------------------------------------------------------------
module request_slot_allocator_top_tb;

	import rsa_pkg::*;

	localparam logic [1:0] OP_BAD      = 2'd3;  // undefined opcode, reported as range error
	localparam int         NUM_RANDOM  = 650;
	localparam int         CYCLE_LIMIT = 100000;
	localparam int         DRAIN_WAIT  = 8;

	typedef struct {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic [KIND_W-1:0] kind;
		logic [HDL_W-1:0]  future;
		logic [HDL_W-1:0]  buffer;
	} slot_item_t;

	typedef struct {
		logic [1:0]        status;
		logic [IDX_W-1:0]  index;
		logic [KIND_W-1:0] kind;
		logic [HDL_W-1:0]  future;
		logic [HDL_W-1:0]  buffer;
	} slot_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        opcode = '0;
	logic [IDX_W-1:0]  slot_index = '0;
	logic [KIND_W-1:0] request_kind = '0;
	logic [HDL_W-1:0]  future_handle = '0;
	logic [HDL_W-1:0]  buffer_handle = '0;
	logic              strobe;
	logic [1:0]        status;
	logic [IDX_W-1:0]  granted_index;
	logic [KIND_W-1:0] stored_kind;
	logic [HDL_W-1:0]  stored_future;
	logic [HDL_W-1:0]  stored_buffer;

	slot_item_t   pending_items[$];
	slot_result_t expected_results[$];
	int           total_items;
	int           accepted_count;
	int           mismatch_count;
	int           cycle_count;

	// predicted allocator state
	logic [IDX_W-1:0] free_idx[SLOTS];
	int               free_top;
	logic             occupied[SLOTS];
	slot_rec_t        slot_store[SLOTS];

	request_slot_allocator_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.slot_index    (slot_index),
		.request_kind  (request_kind),
		.future_handle (future_handle),
		.buffer_handle (buffer_handle),
		.strobe        (strobe),
		.status        (status),
		.granted_index (granted_index),
		.stored_kind   (stored_kind),
		.stored_future (stored_future),
		.stored_buffer (stored_buffer)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [HDL_W-1:0] rand_handle();
		return {$urandom, $urandom};
	endfunction

	task automatic add_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input logic [KIND_W-1:0] kind, input logic [HDL_W-1:0] future,
			input logic [HDL_W-1:0] buffer);
		slot_item_t it;
		it.op     = op;
		it.idx    = idx;
		it.kind   = kind;
		it.future = future;
		it.buffer = buffer;
		pending_items.push_back(it);
	endtask

	// random item with the given opcode mix in percent
	task automatic add_random_item(input int alloc_pct, input int lookup_pct,
			input int release_pct);
		int               roll;
		logic [1:0]       op;
		logic [IDX_W-1:0] idx;
		logic [HDL_W-1:0] buffer;
		roll = $urandom_range(99);
		if (roll < alloc_pct)
			op = OP_ALLOC;
		else if (roll < alloc_pct + lookup_pct)
			op = OP_LOOKUP;
		else if (roll < alloc_pct + lookup_pct + release_pct)
			op = OP_RELEASE;
		else
			op = OP_BAD;
		// the stack hands out high indices first, so lean toward them
		if ($urandom_range(1))
			idx = IDX_W'($urandom_range(63, 32));
		else
			idx = IDX_W'($urandom_range(63));
		buffer = ($urandom_range(4) == 0) ? '0 : rand_handle();
		add_item(op, idx, KIND_W'($urandom_range(255)), rand_handle(), buffer);
	endtask

	function automatic slot_result_t predict_slot_op(input slot_item_t it);
		slot_result_t     r;
		logic [IDX_W-1:0] slot;
		r = '{status: STS_OK, index: '0, kind: '0, future: '0, buffer: '0};
		if (it.op == OP_ALLOC) begin
			if (free_top < 0) begin
				r.status = STS_FULL;
			end else begin
				slot = free_idx[free_top];
				free_top--;
				occupied[slot]   = 1'b1;
				slot_store[slot] = '{kind: it.kind, future: it.future, buffer: it.buffer};
				r.index = slot;
			end
		end else begin
			r.index = it.idx;
			if (it.op == OP_BAD || int'(it.idx) >= SLOTS) begin
				r.status = STS_RANGE;
			end else if (!occupied[it.idx]) begin
				r.status = STS_FREE;
			end else if (it.op == OP_LOOKUP) begin
				r.kind   = slot_store[it.idx].kind;
				r.future = slot_store[it.idx].future;
				r.buffer = slot_store[it.idx].buffer;
			end else begin
				occupied[it.idx] = 1'b0;
				if (free_top < SLOTS - 1) begin
					free_top++;
					free_idx[free_top] = it.idx;
				end
			end
		end
		return r;
	endfunction

	function automatic int sender_idle_pct();
		if (accepted_count < total_items / 3)
			return 32;
		else if (accepted_count < 2 * total_items / 3)
			return 47;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_items
		slot_item_t acc;
		slot_item_t nxt;
		if (!arst_n) begin
			start         <= 1'b0;
			opcode        <= '0;
			slot_index    <= '0;
			request_kind  <= '0;
			future_handle <= '0;
			buffer_handle <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				free_idx[i] = IDX_W'(i);
				occupied[i] = 1'b0;
			end
			free_top = SLOTS - 1;
		end else begin
			if (start && !busy) begin
				acc = '{op: opcode, idx: slot_index, kind: request_kind,
					future: future_handle, buffer: buffer_handle};
				expected_results.push_back(predict_slot_op(acc));
				accepted_count++;
			end
			// a pending item holds until busy drops
			if (!start || !busy) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					nxt = pending_items.pop_front();
					opcode        <= nxt.op;
					slot_index    <= nxt.idx;
					request_kind  <= nxt.kind;
					future_handle <= nxt.future;
					buffer_handle <= nxt.buffer;
					start         <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		slot_result_t want;
		if (arst_n && strobe) begin
			if (expected_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result with no item outstanding: status %0d index %0d",
						$realtime, status, granted_index);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || granted_index !== want.index ||
						stored_kind !== want.kind || stored_future !== want.future ||
						stored_buffer !== want.buffer) begin
					if (mismatch_count < 10) begin
						$display("%0t: mismatch exp status %0d index %0d kind %h future %h buffer %h",
							$realtime, want.status, want.index, want.kind, want.future,
							want.buffer);
						$display("%0t:          got status %0d index %0d kind %h future %h buffer %h",
							$realtime, status, granted_index, stored_kind, stored_future,
							stored_buffer);
					end
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("request_slot_allocator_top regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int mode;
		int burst;
		// free slots, undefined opcode, extremes of the stored fields, LIFO reuse,
		// double release
		add_item(OP_LOOKUP, 6'd0, '0, '0, '0);
		add_item(OP_RELEASE, 6'd63, '1, '1, '1);
		add_item(OP_BAD, 6'd63, '1, '1, '1);
		add_item(OP_BAD, 6'd0, '0, '0, '0);
		add_item(OP_ALLOC, 6'd0, '1, '1, '1);
		add_item(OP_LOOKUP, 6'd63, '0, '0, '0);
		add_item(OP_ALLOC, 6'd63, '0, '0, '0);
		add_item(OP_LOOKUP, 6'd62, '1, '1, '1);
		add_item(OP_RELEASE, 6'd62, '0, '0, '0);
		add_item(OP_LOOKUP, 6'd62, '0, '0, '0);
		add_item(OP_RELEASE, 6'd62, '0, '0, '0);
		add_item(OP_ALLOC, 6'd17, 8'h5a, rand_handle(), '0);
		add_item(OP_LOOKUP, 6'd62, '0, '0, '0);
		add_item(OP_RELEASE, 6'd63, '0, '0, '0);
		add_item(OP_ALLOC, 6'd42, 8'ha5, rand_handle(), rand_handle());
		add_item(OP_LOOKUP, 6'd63, '0, '0, '0);
		add_item(OP_RELEASE, 6'd63, '0, '0, '0);
		add_item(OP_RELEASE, 6'd62, '0, '0, '0);

		// open with a fill burst so the stack runs dry early
		mode = 0;
		while (pending_items.size() < NUM_RANDOM + 18) begin
			burst = (mode == 2) ? 40 : $urandom_range(80, 30);
			repeat (burst) begin
				case (mode)
					0:       add_random_item(85, 10, 4);
					1:       add_random_item(5, 15, 78);
					default: add_random_item(40, 30, 26);
				endcase
			end
			mode = $urandom_range(2);
		end
		total_items = pending_items.size();

		@(posedge arst_n);
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("request_slot_allocator_top regression: pass");
		else
			$display("request_slot_allocator_top regression: fail");
		$finish;
	end

endmodule
